[hw/rtl/salc_pkg.sv]
// Package for the set-associative LRU cache tag block: sizes, register and
// counter codes, and the per-set metadata row type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int WAY_W        = 3;
  localparam int SET_COUNT    = 1 << MAX_SET_BITS;
  localparam int NUM_LINES    = SET_COUNT * MAX_WAYS;
  localparam int ADDR_W       = 64;
  localparam int CNT_W        = 32;
  localparam int NUM_CNT      = 6;

  localparam int OFS_W  = 4;
  localparam int IDX_W  = 3;
  localparam int WLOG_W = 2;
  localparam int CFG_W  = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG    = 2'd2;

  // Event counter slots
  localparam int CNT_ACCESSES     = 0;
  localparam int CNT_READS        = 1;
  localparam int CNT_WRITES       = 2;
  localparam int CNT_READ_MISSES  = 3;
  localparam int CNT_WRITE_MISSES = 4;
  localparam int CNT_WRITE_BACKS  = 5;

  typedef struct packed {
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0]            dirty;
    logic [MAX_WAYS-1:0][WAY_W-1:0] rank;
  } meta_row_t;

  localparam int META_W = $bits(meta_row_t);

  // Row contents before a set is first written: nothing valid, rank = way
  function automatic meta_row_t reset_row();
    meta_row_t r;
    r.valid = '0;
    r.dirty = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      r.rank[w] = WAY_W'(w);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/salc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/set_assoc_lru_cache_tags.sv]
// Top level of the set-associative write-back LRU cache tag block.
// Uses salc_pkg and two salc_ram instances (tag store, per-set metadata).
// Sequence: prep, metadata read, then one tag read and one 64-bit compare per
//   way probed (1 up to 2^ways_log), then update; done_o is registered from update.
// One access at a time: busy is high from the cycle after acceptance until the
//   update cycle ends, and the receiver cannot stall.
// Reset: sets read as empty with ranks equal to way numbers (per-set valid
//   flops, no clearing pass), counters zero, registers at their defaults.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_tags (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [salc_pkg::CFG_W-1:0]       cfg_wdata_i,
  // access command
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             req_type_i,
  input  wire logic [salc_pkg::ADDR_W-1:0]      address_i,
  // result beat
  output logic                                  done_o,
  output logic                                  is_hit_o,
  output logic                                  caused_write_back_o,
  output logic [salc_pkg::WAY_W-1:0]            way_used_o,
  output logic [salc_pkg::MAX_SET_BITS-1:0]     set_used_o,
  output logic [salc_pkg::CNT_W-1:0]            count_accesses_o,
  output logic [salc_pkg::CNT_W-1:0]            count_reads_o,
  output logic [salc_pkg::CNT_W-1:0]            count_writes_o,
  output logic [salc_pkg::CNT_W-1:0]            count_read_misses_o,
  output logic [salc_pkg::CNT_W-1:0]            count_write_misses_o,
  output logic [salc_pkg::CNT_W-1:0]            count_write_backs_o
);

  import salc_pkg::*;

  localparam int LINE_W  = MAX_SET_BITS + WAY_W;
  localparam int SHIFT_W = 5;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_MREAD = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic [OFS_W-1:0]  offset_bits_q;
  logic [IDX_W-1:0]  index_bits_q;
  logic [WLOG_W-1:0] ways_log_q;

  // Access context
  logic                    wr_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [MAX_SET_BITS-1:0] set_q;
  logic [ADDR_W-1:0]       tag_q;
  logic [WAY_W-1:0]        way_q, way_d;
  logic                    hit_q, hit_d;
  meta_row_t               meta_q;

  // Per-set "row written" flags; an unwritten row reads as the reset row
  logic [SET_COUNT-1:0] rowv_q;

  // Event counters
  logic [NUM_CNT-1:0][CNT_W-1:0] cnt_q;
  logic [NUM_CNT-1:0]            cnt_inc;

  // Result registers
  logic                    done_q;
  logic                    res_hit_q;
  logic                    res_wb_q;
  logic [WAY_W-1:0]        res_way_q;
  logic [MAX_SET_BITS-1:0] res_set_q;

  // RAM ports
  logic              tag_re, tag_we;
  logic [LINE_W-1:0] tag_raddr, tag_waddr;
  logic [WAY_W-1:0]  tag_rd_way;
  logic [ADDR_W-1:0] tag_rdata;
  logic              meta_re, meta_we;
  meta_row_t         meta_rdata, meta_new;
  logic [META_W-1:0] meta_rdata_raw;

  // Address split
  logic [IDX_W-1:0]        sbits;
  logic [MAX_SET_BITS:0]   smask_full;
  logic [MAX_SET_BITS-1:0] set_calc;
  logic [SHIFT_W-1:0]      tag_shift;
  logic [ADDR_W-1:0]       tag_calc;
  logic [WAY_W-1:0]        last_way;

  // Update datapath
  logic             tag_match;
  logic [WAY_W-1:0] vict_way;
  logic             found_inv;
  logic [WAY_W-1:0] fin_way;
  logic             wb;
  logic [WAY_W-1:0] old_rank;

  assign busy = (state_q != S_IDLE);

  // Clamp the set index width; ways_log tops out at the full way count
  assign sbits      = (index_bits_q > IDX_W'(MAX_SET_BITS)) ? IDX_W'(MAX_SET_BITS)
                                                             : index_bits_q;
  assign smask_full = ((MAX_SET_BITS+1)'(1) << sbits) - (MAX_SET_BITS+1)'(1);
  assign set_calc   = MAX_SET_BITS'(addr_q >> offset_bits_q) & smask_full[MAX_SET_BITS-1:0];
  assign tag_shift  = SHIFT_W'(offset_bits_q) + SHIFT_W'(sbits);
  assign tag_calc   = addr_q >> tag_shift;
  assign last_way   = WAY_W'(((WAY_W+1)'(1) << ways_log_q) - (WAY_W+1)'(1));

  // One way per cycle through the shared comparator
  assign tag_match = meta_q.valid[way_q] && (tag_rdata == tag_q);

  assign meta_re    = (state_q == S_PREP);
  assign tag_rd_way = (state_q == S_CMP) ? (way_q + WAY_W'(1)) : '0;
  assign tag_raddr  = {set_q, tag_rd_way};
  assign meta_rdata = meta_row_t'(meta_rdata_raw);

  // Sequencer
  always_comb begin
    state_d = state_q;
    way_d   = way_q;
    hit_d   = hit_q;
    tag_re  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        way_d   = '0;
        state_d = S_MREAD;
      end
      S_MREAD: begin
        tag_re  = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (tag_match) begin
          hit_d   = 1'b1;
          state_d = S_UPD;
        end else if (way_q == last_way) begin
          hit_d   = 1'b0;
          state_d = S_UPD;
        end else begin
          // advance to the next way and fetch its tag
          tag_re = 1'b1;
          way_d  = way_q + WAY_W'(1);
        end
      end
      S_UPD: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Victim: lowest invalid way in use, else the in-use way with the top rank
  always_comb begin
    vict_way  = '0;
    found_inv = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!found_inv && (WAY_W'(w) <= last_way) && !meta_q.valid[w]) begin
        vict_way  = WAY_W'(w);
        found_inv = 1'b1;
      end
    end
    if (!found_inv) begin
      vict_way = '0;
      for (int w = 1; w < MAX_WAYS; w++) begin
        if ((WAY_W'(w) <= last_way) && (meta_q.rank[w] > meta_q.rank[vict_way])) begin
          vict_way = WAY_W'(w);
        end
      end
    end
  end

  assign fin_way  = hit_q ? way_q : vict_way;
  assign wb       = !hit_q && meta_q.valid[fin_way] && meta_q.dirty[fin_way];
  assign old_rank = meta_q.rank[fin_way];

  // New metadata row: fill or mark dirty, then promote to most recent
  always_comb begin
    meta_new = meta_q;
    if (hit_q) begin
      meta_new.dirty[fin_way] = meta_q.dirty[fin_way] | wr_q;
    end else begin
      meta_new.valid[fin_way] = 1'b1;
      meta_new.dirty[fin_way] = wr_q;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (meta_q.rank[w] < old_rank) begin
        meta_new.rank[w] = meta_q.rank[w] + WAY_W'(1);
      end
    end
    meta_new.rank[fin_way] = '0;
  end

  assign meta_we   = (state_q == S_UPD);
  assign tag_we    = (state_q == S_UPD) && !hit_q;
  assign tag_waddr = {set_q, fin_way};

  // Counter bumps for this access
  always_comb begin
    cnt_inc                   = '0;
    cnt_inc[CNT_ACCESSES]     = 1'b1;
    cnt_inc[CNT_READS]        = !wr_q;
    cnt_inc[CNT_WRITES]       = wr_q;
    cnt_inc[CNT_READ_MISSES]  = !hit_q && !wr_q;
    cnt_inc[CNT_WRITE_MISSES] = !hit_q && wr_q;
    cnt_inc[CNT_WRITE_BACKS]  = wb;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      done_q        <= 1'b0;
      rowv_q        <= '0;
      cnt_q         <= '0;
      offset_bits_q <= OFS_W'(5);
      index_bits_q  <= IDX_W'(6);
      ways_log_q    <= WLOG_W'(3);
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_UPD);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OFFSET_BITS: offset_bits_q <= cfg_wdata_i[OFS_W-1:0];
          REG_INDEX_BITS:  index_bits_q  <= cfg_wdata_i[IDX_W-1:0];
          REG_WAYS_LOG:    ways_log_q    <= cfg_wdata_i[WLOG_W-1:0];
          default: ;
        endcase
      end
      if (state_q == S_UPD) begin
        rowv_q[set_q] <= 1'b1;
        for (int k = 0; k < NUM_CNT; k++) begin
          // saturate at all ones
          if (cnt_inc[k] && (cnt_q[k] != {CNT_W{1'b1}})) begin
            cnt_q[k] <= cnt_q[k] + CNT_W'(1);
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    way_q <= way_d;
    hit_q <= hit_d;
    if (state_q == S_IDLE && start) begin
      wr_q   <= req_type_i;
      addr_q <= address_i;
    end
    if (state_q == S_PREP) begin
      set_q <= set_calc;
      tag_q <= tag_calc;
    end
    if (state_q == S_MREAD) begin
      meta_q <= rowv_q[set_q] ? meta_rdata : reset_row();
    end
    if (state_q == S_UPD) begin
      res_hit_q <= hit_q;
      res_wb_q  <= wb;
      res_way_q <= fin_way;
      res_set_q <= set_q;
    end
  end

  salc_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (NUM_LINES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_q),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  salc_ram #(
    .WIDTH (META_W),
    .DEPTH (SET_COUNT)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (set_q),
    .wdata_i (meta_new),
    .re_i    (meta_re),
    .raddr_i (set_calc),
    .rdata_o (meta_rdata_raw)
  );

  // Drive the result beat; counters only move in the update cycle
  assign done_o               = done_q;
  assign is_hit_o             = res_hit_q;
  assign caused_write_back_o  = res_wb_q;
  assign way_used_o           = res_way_q;
  assign set_used_o           = res_set_q;
  assign count_accesses_o     = cnt_q[CNT_ACCESSES];
  assign count_reads_o        = cnt_q[CNT_READS];
  assign count_writes_o       = cnt_q[CNT_WRITES];
  assign count_read_misses_o  = cnt_q[CNT_READ_MISSES];
  assign count_write_misses_o = cnt_q[CNT_WRITE_MISSES];
  assign count_write_backs_o  = cnt_q[CNT_WRITE_BACKS];

endmodule

`default_nettype wire
